### rtl/stereo_ramped_gain_unit_defines.svh
// Assertion macros used by the stereo ramped gain controller.
`ifndef STEREO_RAMPED_GAIN_UNIT_DEFINES_SVH
`define STEREO_RAMPED_GAIN_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define SRG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define SRG_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/srg_pkg.sv
// Types, constants and control structs of the stereo ramped gain unit.
`timescale 1ns / 1ps

package srg_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int SAMPLE_BITS   = 24;
    localparam int RAMP_BITS     = 16;
    localparam int SLOT_BITS     = 3;
    localparam int CMD_BITS      = 2;
    localparam int GAIN_BITS     = 20;
    localparam int GAIN_SHIFT    = 16;
    localparam int CUR_BITS      = GAIN_BITS + GAIN_SHIFT;
    localparam int STEP_BITS     = CUR_BITS + 1;
    localparam int CUR_FRAC      = 32;

    localparam logic [GAIN_BITS-1:0] GAIN_MAX_Q16 = GAIN_BITS'(655360);
    localparam logic [GAIN_BITS-1:0] UNITY_Q16    = GAIN_BITS'(65536);
    localparam logic [CUR_BITS-1:0]  UNITY_Q32    = CUR_BITS'(1) << CUR_FRAC;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_PROCESS = 2'd0,
        CMD_SET     = 2'd1,
        CMD_RESET   = 2'd2
    } cmd_e;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PROCESS,
        KIND_SET,
        KIND_RESET
    } kind_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]           cmd;
        logic [SLOT_BITS-1:0]          slot;
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic [GAIN_BITS-1:0]          gain_value;
        logic [RAMP_BITS-1:0]          ramp_len;
    } req_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          accepted;
    } res_t;

    typedef struct packed {
        logic [CUR_BITS-1:0]         cur;
        logic [GAIN_BITS-1:0]        tgt;
        logic signed [STEP_BITS-1:0] step;
        logic [RAMP_BITS-1:0]        frames;
    } entry_t;

    localparam entry_t ENTRY_UNITY = '{
        cur:    UNITY_Q32,
        tgt:    UNITY_Q16,
        step:   '0,
        frames: '0
    };

    typedef struct packed {
        logic load;
        logic read;
        logic capture;
        logic advance;
        logic mul;
        logic sat;
        logic chan;
        logic div_start;
        logic set_apply;
        logic write;
        logic clear_valid;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  ramp_active;
        logic  set_ramp;
        logic  div_done;
    } ctl_status_t;

endpackage

### rtl/srg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module srg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/srg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module srg_div #(
    parameter int DW = 36,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;

    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] rem_step;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DW-1]};
        fits     = trial >= {1'b0, divisor};
        rem_step = fits ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
    end

    // Sequence the iterations and flag the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= rem_step;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/srg_datapath.sv
// Datapath: slot state memory, ramp update, shared multiplier, divider, result registers.
`timescale 1ns / 1ps

module srg_datapath import srg_pkg::*; #(
    parameter int SLOTS   = SLOTS_DEFAULT,
    parameter int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  ctl_cmd_t    ctl,
    output ctl_status_t status,
    output res_t        res
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + 5;
    localparam logic [PW-1:0] LIM_NEG = {5'b0, 1'b1, {(SB-1){1'b0}}};
    localparam logic [PW-1:0] LIM_POS = {5'b0, 1'b0, {(SB-1){1'b1}}};

    req_t                   req_reg;
    entry_t                 ent_reg;
    entry_t                 ram_rdata;
    logic [SLOTS-1:0]       valid_reg;
    logic                   hit_reg;
    logic [SLOT_AW-1:0]     addr;
    logic                   slot_ok;
    kind_t                  kind;

    logic [SB-1:0]          mag_l_reg;
    logic [SB-1:0]          mag_r_reg;
    logic                   neg_l_reg;
    logic                   neg_r_reg;
    logic [SB+CUR_FRAC-1:0] plo_reg;
    logic [SB+3:0]          phi_reg;
    logic [SB-1:0]          res_left_reg;
    logic [SB-1:0]          res_right_reg;
    logic                   res_acc_reg;
    res_t                   out_reg;
    logic                   div_neg_reg;

    logic signed [CUR_BITS+1:0] sum_adv;
    logic [CUR_BITS-1:0]    cur_clamped;
    logic [RAMP_BITS-1:0]   frames_dec;
    logic [CUR_BITS-1:0]    tgt_q32;
    logic                   up;
    logic [CUR_BITS-1:0]    dividend;
    logic [CUR_BITS-1:0]    quotient;
    logic                   div_done;
    logic [STEP_BITS-1:0]   q_ext;
    logic [STEP_BITS-1:0]   step_new;
    logic [SB-1:0]          mag_sel;
    logic                   neg_sel;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          prod_lim;
    logic [SB-1:0]          sat_val;
    logic [SB-1:0]          left_abs;
    logic [SB-1:0]          right_abs;

    assign addr    = SLOT_AW'(req_reg.slot);
    assign slot_ok = 32'(req_reg.slot) < 32'(SLOTS);

    // Decode the held request
    always_comb
    begin
        kind = KIND_NONE;
        if (slot_ok)
        begin
            unique case (req_reg.cmd)
                CMD_PROCESS: kind = KIND_PROCESS;
                CMD_SET:     kind = (req_reg.gain_value > GAIN_MAX_Q16) ? KIND_NONE : KIND_SET;
                CMD_RESET:   kind = KIND_RESET;
                default:     kind = KIND_NONE;
            endcase
        end
    end

    // Ramp advance: add the step, clamp, snap to target on the last frame
    always_comb
    begin
        sum_adv = $signed({2'b00, ent_reg.cur})
                + $signed({ent_reg.step[STEP_BITS-1], ent_reg.step});
        if (sum_adv[CUR_BITS+1])
        begin
            cur_clamped = '0;
        end
        else if (sum_adv[CUR_BITS])
        begin
            cur_clamped = '1;
        end
        else
        begin
            cur_clamped = sum_adv[CUR_BITS-1:0];
        end
        frames_dec = ent_reg.frames - 1'b1;
    end

    // Ramp step: magnitude of target minus current, sign kept aside
    always_comb
    begin
        tgt_q32  = {req_reg.gain_value, {GAIN_SHIFT{1'b0}}};
        up       = tgt_q32 >= ent_reg.cur;
        dividend = up ? (tgt_q32 - ent_reg.cur) : (ent_reg.cur - tgt_q32);
        q_ext    = {1'b0, quotient};
        step_new = div_neg_reg ? (~q_ext + 1'b1) : q_ext;
    end

    srg_div #(
        .DW (CUR_BITS),
        .VW (RAMP_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (dividend),
        .divisor  (req_reg.ramp_len),
        .done     (div_done),
        .quotient (quotient)
    );

    srg_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOTS),
        .AW    (SLOT_AW)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.write),
        .waddr (addr),
        .wdata (ent_reg),
        .re    (ctl.read),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    // Sample magnitudes and saturation of the truncated product
    always_comb
    begin
        left_abs  = req_reg.left_in[SB-1] ? (~req_reg.left_in + 1'b1) : req_reg.left_in;
        right_abs = req_reg.right_in[SB-1] ? (~req_reg.right_in + 1'b1) : req_reg.right_in;
        mag_sel   = ctl.chan ? mag_r_reg : mag_l_reg;
        neg_sel   = ctl.chan ? neg_r_reg : neg_l_reg;
        prod      = {1'b0, phi_reg} + {5'b0, plo_reg[SB+CUR_FRAC-1:CUR_FRAC]};
        if (neg_sel)
        begin
            prod_lim = (prod > LIM_NEG) ? LIM_NEG : prod;
            sat_val  = ~prod_lim[SB-1:0] + 1'b1;
        end
        else
        begin
            prod_lim = (prod > LIM_POS) ? LIM_POS : prod;
            sat_val  = prod_lim[SB-1:0];
        end
    end

    // Valid bits: an entry never written reads as unity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.write)
        begin
            valid_reg[addr] <= 1'b1;
        end
        else if (ctl.clear_valid)
        begin
            valid_reg[addr] <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= req;
        end
        if (ctl.read)
        begin
            hit_reg <= valid_reg[addr];
        end
        if (ctl.capture)
        begin
            ent_reg       <= hit_reg ? ram_rdata : ENTRY_UNITY;
            mag_l_reg     <= left_abs;
            mag_r_reg     <= right_abs;
            neg_l_reg     <= req_reg.left_in[SB-1];
            neg_r_reg     <= req_reg.right_in[SB-1];
            res_left_reg  <= '0;
            res_right_reg <= '0;
            res_acc_reg   <= kind != KIND_NONE;
        end
        if (ctl.advance)
        begin
            ent_reg.frames <= frames_dec;
            ent_reg.cur    <= (frames_dec == '0) ? {ent_reg.tgt, {GAIN_SHIFT{1'b0}}}
                                                 : cur_clamped;
        end
        if (ctl.div_start)
        begin
            div_neg_reg <= !up;
        end
        if (ctl.set_apply)
        begin
            ent_reg.tgt    <= req_reg.gain_value;
            ent_reg.frames <= req_reg.ramp_len;
            if (req_reg.ramp_len != '0)
            begin
                ent_reg.step <= $signed(step_new);
            end
            else
            begin
                ent_reg.cur <= tgt_q32;
            end
        end
        if (ctl.mul)
        begin
            plo_reg <= mag_sel * ent_reg.cur[CUR_FRAC-1:0];
            phi_reg <= mag_sel * ent_reg.cur[CUR_BITS-1:CUR_FRAC];
        end
        if (ctl.sat)
        begin
            if (ctl.chan)
            begin
                res_right_reg <= sat_val;
            end
            else
            begin
                res_left_reg <= sat_val;
            end
        end
        if (ctl.out_load)
        begin
            out_reg.left_out  <= $signed(res_left_reg);
            out_reg.right_out <= $signed(res_right_reg);
            out_reg.accepted  <= res_acc_reg;
        end
    end

    assign status.kind        = kind;
    assign status.ramp_active = ent_reg.frames != '0;
    assign status.set_ramp    = req_reg.ramp_len != '0;
    assign status.div_done    = div_done;
    assign res                = out_reg;

endmodule

### rtl/srg_ctrl.sv
// Controller: sequences each request through the datapath and owns the handshakes.
`timescale 1ns / 1ps

`include "stereo_ramped_gain_unit_defines.svh"

module srg_ctrl import srg_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    output logic        res_valid,
    input  logic        res_stall,
    input  ctl_status_t status,
    output ctl_cmd_t    ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_ENTRY,
        S_DISPATCH,
        S_ADV,
        S_MUL_L,
        S_SAT_L,
        S_MUL_R,
        S_SAT_R,
        S_DIV_WAIT,
        S_WB,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    assign req_stall = state_reg != S_IDLE;
    assign res_valid = res_valid_reg;

    // Next state, datapath commands and result valid
    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        res_valid_next = res_valid_reg && res_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                ctl.read   = 1'b1;
                state_next = S_ENTRY;
            end
            S_ENTRY:
            begin
                ctl.capture = 1'b1;
                state_next  = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (status.kind)
                    KIND_PROCESS:
                    begin
                        state_next = status.ramp_active ? S_ADV : S_MUL_L;
                    end
                    KIND_SET:
                    begin
                        if (status.set_ramp)
                        begin
                            ctl.div_start = 1'b1;
                            state_next    = S_DIV_WAIT;
                        end
                        else
                        begin
                            ctl.set_apply = 1'b1;
                            state_next    = S_WB;
                        end
                    end
                    KIND_RESET:
                    begin
                        ctl.clear_valid = 1'b1;
                        state_next      = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ADV:
            begin
                ctl.advance = 1'b1;
                state_next  = S_MUL_L;
            end
            S_MUL_L:
            begin
                ctl.mul    = 1'b1;
                state_next = S_SAT_L;
            end
            S_SAT_L:
            begin
                ctl.sat    = 1'b1;
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                ctl.mul    = 1'b1;
                ctl.chan   = 1'b1;
                state_next = S_SAT_R;
            end
            S_SAT_R:
            begin
                ctl.sat    = 1'b1;
                ctl.chan   = 1'b1;
                state_next = S_WB;
            end
            S_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    ctl.set_apply = 1'b1;
                    state_next    = S_WB;
                end
            end
            S_WB:
            begin
                ctl.write  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hand over once the result register is free
                if (!res_valid_reg || !res_stall)
                begin
                    ctl.out_load   = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    `SRG_ASSERT_IMP(a_div_done_in_wait, status.div_done, state_reg == S_DIV_WAIT)
    `SRG_ASSERT_IMP(a_apply_only_on_set, ctl.set_apply, status.kind == KIND_SET)
    `SRG_ASSERT_NXT(a_done_waits_for_room, state_reg == S_DONE && res_valid_reg && res_stall, state_reg == S_DONE)

endmodule

### rtl/stereo_ramped_gain_unit.sv
// Top level of the stereo ramped gain unit: controller plus datapath.
`timescale 1ns / 1ps

//  channel  | payload | handshake               | direction
//  request  | req     | req_valid / req_stall   | into the unit
//  result   | res     | res_valid / res_stall   | out of the unit
//
//  One request at a time; each gives exactly one result.
//  Process: a ramp step when one is active, then the shared multiplier used twice per frame.
//  Set with a ramp: waits for the 36-step serial divider.
//  Set without a ramp, reset, reject or unused command: no multiplier or divider pass.
//  Reset (rst_n, asynchronous) brings every slot to unity at once through valid bits.
//  A held result does not block the next request; only its hand-over waits.

module stereo_ramped_gain_unit import srg_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    ctl_cmd_t    ctl;
    ctl_status_t status;

    srg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .ctl       (ctl)
    );

    srg_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .ctl    (ctl),
        .status (status),
        .res    (res)
    );

endmodule
